/* design/load_cell_adc_serial_reader_unit_macros.svh */
// Assertion helpers used by the top-level reader unit.
`ifndef LOAD_CELL_ADC_SERIAL_READER_UNIT_MACROS_SVH
`define LOAD_CELL_ADC_SERIAL_READER_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LCASR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcasr check failed");

// Next-cycle implication, held off during reset.
`define LCASR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcasr check failed");

`endif

/* design/lcasr_pkg.sv */
`default_nettype none

package lcasr_pkg;

    localparam int READING_W = 32;
    localparam int GAIN_W    = 2;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 2'd1;

    typedef struct packed {
        logic sck;
        logic complete;
    } t_frame;

    typedef struct packed {
        logic reading_valid;
        logic taring;
        logic tare_done;
    } t_tare_stat;

endpackage

`default_nettype wire

/* design/lcasr_frame.sv */
`default_nettype none

module lcasr_frame
    import lcasr_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic                   i_dout_level,
    input  wire logic [GAIN_W-1:0]      i_gain_pulses,
    output t_frame                      o_frame,
    output logic      [SAMPLE_BITS-1:0] o_raw
);

    localparam int BIT_W = $clog2(SAMPLE_BITS);

    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_HIGH  = 3'd1;
    localparam logic [2:0] PH_LOW   = 3'd2;
    localparam logic [2:0] PH_XHIGH = 3'd3;
    localparam logic [2:0] PH_XLOW  = 3'd4;

    logic [2:0]             r_phase, n_phase;
    logic [BIT_W-1:0]       r_bit_cnt, n_bit_cnt;
    logic [SAMPLE_BITS-1:0] r_shift, n_shift;
    logic [GAIN_W-1:0]      r_pulse_cnt, n_pulse_cnt;
    logic [GAIN_W-1:0]      w_need;
    logic                   w_sck;
    logic                   w_complete;

    assign w_need = (i_gain_pulses == '0) ? GAIN_W'(1) : i_gain_pulses;

    always_comb begin
        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_pulse_cnt = r_pulse_cnt;
        w_sck       = 1'b0;
        w_complete  = 1'b0;
        unique case (r_phase)
            PH_HIGH: begin
                w_sck   = 1'b1;
                n_shift = {r_shift[SAMPLE_BITS-2:0], i_dout_level};
                n_phase = PH_LOW;
            end
            PH_LOW: begin
                if (r_bit_cnt == BIT_W'(SAMPLE_BITS - 1)) begin
                    n_bit_cnt   = '0;
                    n_pulse_cnt = '0;
                    n_phase     = PH_XHIGH;
                end else begin
                    n_bit_cnt = r_bit_cnt + BIT_W'(1);
                    n_phase   = PH_HIGH;
                end
            end
            PH_XHIGH: begin
                w_sck   = 1'b1;
                n_phase = PH_XLOW;
            end
            PH_XLOW: begin
                if ({1'b0, r_pulse_cnt} + (GAIN_W+1)'(1) >= {1'b0, w_need}) begin
                    n_pulse_cnt = '0;
                    n_phase     = PH_WAIT;
                    w_complete  = 1'b1;
                end else begin
                    n_pulse_cnt = r_pulse_cnt + GAIN_W'(1);
                    n_phase     = PH_XHIGH;
                end
            end
            default: begin
                n_phase = PH_WAIT;
                if (!i_dout_level) begin
                    n_bit_cnt = '0;
                    n_shift   = '0;
                    n_phase   = PH_HIGH;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_pulse_cnt <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_bit_cnt   <= n_bit_cnt;
            r_shift     <= n_shift;
            r_pulse_cnt <= n_pulse_cnt;
        end
    end

    assign o_frame.sck      = w_sck;
    assign o_frame.complete = w_complete;
    assign o_raw            = r_shift;

endmodule

`default_nettype wire

/* design/lcasr_div.sv */
`default_nettype none

module lcasr_div #(
    parameter int SAMPLE_BITS  = 24,
    parameter int TARE_SAMPLES = 5
) (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    input  wire logic                                            i_start,
    input  wire logic [SAMPLE_BITS+$clog2(TARE_SAMPLES+1)-1:0]   i_dividend,
    output logic                                                 o_busy,
    output logic                                                 o_done,
    output logic      [SAMPLE_BITS-1:0]                          o_quotient
);

    localparam int SUM_W   = SAMPLE_BITS + $clog2(TARE_SAMPLES + 1);
    localparam int SHIFT   = SUM_W + $clog2(TARE_SAMPLES);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(TARE_SAMPLES) - 64'd1) / 64'(TARE_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic              r_pend;
    logic [SUM_W-1:0]  r_dividend;
    logic [PROD_W-1:0] w_product;

    // multiply by the rounded-up reciprocal; exact floor for every dividend that fits SUM_W
    assign w_product = {{RECIP_W{1'b0}}, r_dividend} * {{SUM_W{1'b0}}, RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= i_dividend;
        end
    end

    assign o_busy     = r_pend;
    assign o_done     = r_pend;
    assign o_quotient = w_product[SHIFT +: SAMPLE_BITS];

endmodule

`default_nettype wire

/* design/lcasr_tare.sv */
`default_nettype none

module lcasr_tare
    import lcasr_pkg::*;
#(
    parameter int SAMPLE_BITS  = 24,
    parameter int TARE_SAMPLES = 5
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic                   i_complete,
    input  wire logic                   i_tare_request,
    input  wire logic [SAMPLE_BITS-1:0] i_raw,
    output t_tare_stat                  o_stat,
    output logic      [READING_W-1:0]   o_reading,
    output logic                        o_div_start,
    output logic                        o_div_busy
);

    localparam int CNT_W = $clog2(TARE_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;

    localparam int FLAG_DISCARD = 0;
    localparam int FLAG_TARE    = 1;

    logic [1:0]             r_flags, n_flags;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [SAMPLE_BITS-1:0] r_offset;
    logic [SUM_W-1:0]       w_sum_add;
    logic [CNT_W:0]         w_cnt_inc;
    logic                   w_start;
    logic                   w_valid;
    logic                   w_done;
    logic [READING_W-1:0]   w_reading;
    logic                   w_div_done;
    logic [SAMPLE_BITS-1:0] w_quotient;

    assign w_sum_add = r_sum + SUM_W'(i_raw);
    assign w_cnt_inc = {1'b0, r_cnt} + (CNT_W+1)'(1);

    always_comb begin
        n_flags   = r_flags;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        w_start   = 1'b0;
        w_valid   = 1'b0;
        w_done    = 1'b0;
        w_reading = '0;
        if (i_complete) begin
            if (r_flags[FLAG_DISCARD]) begin
                n_flags[FLAG_DISCARD] = 1'b0;
            end else if (r_flags[FLAG_TARE]) begin
                if (w_cnt_inc >= (CNT_W+1)'(TARE_SAMPLES)) begin
                    n_sum              = '0;
                    n_cnt              = '0;
                    n_flags[FLAG_TARE] = 1'b0;
                    w_start            = 1'b1;
                    w_done             = 1'b1;
                end else begin
                    n_sum = w_sum_add;
                    n_cnt = w_cnt_inc[CNT_W-1:0];
                end
            end else begin
                w_reading = READING_W'(i_raw) - READING_W'(r_offset);
                w_valid   = 1'b1;
            end
        end
        if (i_tare_request) begin
            n_sum              = '0;
            n_cnt              = '0;
            n_flags[FLAG_TARE] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags  <= 2'b11;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_offset <= '0;
        end else begin
            if (i_step) begin
                r_flags <= n_flags;
                r_sum   <= n_sum;
                r_cnt   <= n_cnt;
            end
            if (w_div_done) begin
                r_offset <= w_quotient;
            end
        end
    end

    lcasr_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TARE_SAMPLES(TARE_SAMPLES)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_step && w_start),
        .i_dividend(w_sum_add),
        .o_busy    (o_div_busy),
        .o_done    (w_div_done),
        .o_quotient(w_quotient)
    );

    assign o_stat.reading_valid = w_valid;
    assign o_stat.taring        = n_flags != 2'b00;
    assign o_stat.tare_done     = w_done;
    assign o_reading            = w_reading;
    assign o_div_start          = i_step && w_start;

endmodule

`default_nettype wire

/* design/load_cell_adc_serial_reader_unit.sv */
// Serial reader for a 24-bit bridge-sensor converter with tare. Each input word is one
// clock half-period tick: the sampled data pin level and a tare request. One word is taken
// per clock cycle and its result word (clock level to drive, reading, flags) is registered
// for the next cycle; the input side stays ready while the output register is empty or
// being drained. A conversion waits for a low data pin, then drives a high and a low tick for each
// data bit and each gain pulse. After reset one conversion is discarded, then TARE_SAMPLES
// raw conversions are averaged into the offset. The average is formed by a reciprocal
// multiplication in the clock cycle after the last tare conversion, in the background;
// the offset is in place long before the next conversion can finish.
// The gain register is written on its own port, which is always ready.
`default_nettype none

`include "load_cell_adc_serial_reader_unit_macros.svh"

module load_cell_adc_serial_reader_unit
    import lcasr_pkg::*;
#(
    parameter int SAMPLE_BITS  = 24,
    parameter int TARE_SAMPLES = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [GAIN_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_dout_level,
    input  wire logic                 i_tare_request,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_sck_level,
    output logic      [READING_W-1:0] o_reading,
    output logic                      o_reading_valid,
    output logic                      o_taring,
    output logic                      o_tare_done
);

    logic [GAIN_W-1:0]      r_gain;
    logic                   r_out_valid;
    logic                   r_sck;
    logic [READING_W-1:0]   r_reading;
    t_tare_stat             r_stat;
    logic                   w_step;
    t_frame                 w_frame;
    logic [SAMPLE_BITS-1:0] w_raw;
    t_tare_stat             w_stat;
    logic [READING_W-1:0]   w_reading;
    logic                   w_div_start;
    logic                   w_div_busy;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_step      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    lcasr_frame #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_dout_level (i_dout_level),
        .i_gain_pulses(r_gain),
        .o_frame      (w_frame),
        .o_raw        (w_raw)
    );

    lcasr_tare #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TARE_SAMPLES(TARE_SAMPLES)
    ) u_tare (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_complete    (w_frame.complete),
        .i_tare_request(i_tare_request),
        .i_raw         (w_raw),
        .o_stat        (w_stat),
        .o_reading     (w_reading),
        .o_div_start   (w_div_start),
        .o_div_busy    (w_div_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_sck     <= w_frame.sck;
            r_reading <= w_reading;
            r_stat    <= w_stat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sck_level     = r_sck;
    assign o_reading       = r_reading;
    assign o_reading_valid = r_stat.reading_valid;
    assign o_taring        = r_stat.taring;
    assign o_tare_done     = r_stat.tare_done;

    `LCASR_ASSERT_NOW(a_no_accept_when_full, i_clk, i_rst_n, r_out_valid && !i_out_ready, !w_step)
    `LCASR_ASSERT_NOW(a_reading_or_tare, i_clk, i_rst_n, o_out_valid, !(o_reading_valid && o_tare_done))
    `LCASR_ASSERT_NOW(a_complete_on_low, i_clk, i_rst_n, w_frame.complete, !w_frame.sck)
    `LCASR_ASSERT_NOW(a_div_idle_at_start, i_clk, i_rst_n, w_div_start, !w_div_busy)

endmodule

`default_nettype wire
